FILE: rtl/slur_pkg.sv
// shared types and constants for the sensor line serial receiver
`timescale 1ns / 1ps
package slur_pkg;

	// width of the bit-timing countdown
	localparam int TickCntW = 17;
	// width used to form bit_period plus half of it before trimming to TickCntW
	localparam int LoadW = (TickCntW > 17) ? TickCntW : 17;

	localparam int BitPeriodW = 16;
	localparam int ByteW      = 8;
	localparam int PosW       = 5;
	localparam int BitsLeftW  = 4;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 16;

	// reset values of the configuration registers
	localparam logic [BitPeriodW-1:0] BitPeriodRst  = 16'd27;
	localparam logic [ByteW-1:0]      TerminatorRst = 8'h0A;
	localparam logic [PosW-1:0]       LastIndexRst  = 5'd12;
	localparam logic [BitsLeftW-1:0]  BitsPerByte   = 4'd8;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgBitPeriod  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgTerminator = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgLastIndex  = 2'd2;

	typedef enum logic [1:0] {
		OpTick  = 2'd0,
		OpStart = 2'd1,
		OpStop  = 2'd2,
		OpSpare = 2'd3
	} op_t;

	typedef struct packed {
		logic [BitPeriodW-1:0] bit_period;
		logic [ByteW-1:0]      terminator;
		logic [PosW-1:0]       last_index;
	} cfg_t;

	typedef struct packed {
		logic             excitation;
		logic             byte_valid;
		logic [ByteW-1:0] byte_value;
		logic [PosW-1:0]  byte_index;
		logic             line_done;
		logic             armed;
	} res_t;

endpackage

FILE: rtl/slur_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps
module slur_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [slur_pkg::CfgIdxW-1:0]  wr_index,
	input  logic [slur_pkg::CfgDataW-1:0] wr_data,
	output slur_pkg::cfg_t                cfg
);
	import slur_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_period <= BitPeriodRst;
			cfg_q.terminator <= TerminatorRst;
			cfg_q.last_index <= LastIndexRst;
		end else if (wr_en) begin
			unique case (wr_index)
				CfgBitPeriod:  cfg_q.bit_period <= wr_data[BitPeriodW-1:0];
				CfgTerminator: cfg_q.terminator <= wr_data[ByteW-1:0];
				CfgLastIndex:  cfg_q.last_index <= wr_data[PosW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/slur_core.sv
// receiver state and the per-tick next-state logic
`timescale 1ns / 1ps
module slur_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  slur_pkg::op_t   op,
	input  logic            level,
	input  slur_pkg::cfg_t  cfg,
	output slur_pkg::res_t  res
);
	import slur_pkg::*;

	logic                 armed_q, n_armed;
	logic                 in_frame_q, n_in_frame;
	logic                 prev_level_q;
	logic [TickCntW-1:0]  countdown_q, n_countdown;
	logic [ByteW-1:0]     shift_q, n_shift;
	logic [BitsLeftW-1:0] bits_left_q, n_bits_left;
	logic [PosW-1:0]      pos_q, n_pos;
	logic                 excite_q, n_excite;

	logic [LoadW-1:0]     first_load;
	logic [ByteW-1:0]     shift_next;
	logic [BitsLeftW-1:0] bits_dec;

	assign first_load = LoadW'(cfg.bit_period) + LoadW'(cfg.bit_period >> 1);
	assign shift_next = {level, shift_q[ByteW-1:1]};
	assign bits_dec   = bits_left_q - 1'b1;

	always_comb begin
		n_armed     = armed_q;
		n_in_frame  = in_frame_q;
		n_countdown = countdown_q;
		n_shift     = shift_q;
		n_bits_left = bits_left_q;
		n_pos       = pos_q;
		n_excite    = excite_q;
		res         = '0;
		if (op == OpStart) begin
			n_armed     = 1'b1;
			n_excite    = 1'b1;
			n_in_frame  = 1'b0;
			n_bits_left = BitsPerByte;
			n_pos       = '0;
		end else begin
			if (op == OpStop) n_excite = 1'b0;
			if (armed_q) begin
				if (!in_frame_q) begin
					// falling edge opens a frame
					if (prev_level_q && !level) begin
						n_in_frame  = 1'b1;
						n_bits_left = BitsPerByte;
						n_countdown = first_load[TickCntW-1:0];
					end
				end else if (countdown_q <= TickCntW'(1)) begin
					n_countdown = TickCntW'(cfg.bit_period);
					n_shift     = shift_next;
					n_bits_left = bits_dec;
					if (bits_dec == '0) begin
						n_bits_left    = BitsPerByte;
						n_in_frame     = 1'b0;
						res.byte_valid = 1'b1;
						res.byte_value = shift_next;
						res.byte_index = pos_q;
						if (shift_next == cfg.terminator || pos_q == cfg.last_index) begin
							res.line_done = 1'b1;
							n_pos         = '0;
							n_excite      = 1'b0;
							n_armed       = 1'b0;
						end else begin
							n_pos = pos_q + 1'b1;
						end
					end
				end else begin
					n_countdown = countdown_q - 1'b1;
				end
			end
		end
		res.excitation = n_excite;
		res.armed      = n_armed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			in_frame_q   <= 1'b0;
			prev_level_q <= 1'b1;
			countdown_q  <= '0;
			shift_q      <= '0;
			bits_left_q  <= BitsPerByte;
			pos_q        <= '0;
			excite_q     <= 1'b0;
		end else if (step) begin
			armed_q      <= n_armed;
			in_frame_q   <= n_in_frame;
			prev_level_q <= level;
			countdown_q  <= n_countdown;
			shift_q      <= n_shift;
			bits_left_q  <= n_bits_left;
			pos_q        <= n_pos;
			excite_q     <= n_excite;
		end
	end

	// a frame only runs while armed
	a_frame_needs_arm: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> armed_q)
		else $error("in frame while not armed");

	a_bits_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bits_left_q != '0) && (bits_left_q <= BitsPerByte))
		else $error("bit counter out of range");

	a_byte_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.byte_valid) |=> !in_frame_q)
		else $error("frame still open after a byte");

endmodule

FILE: rtl/sensor_line_uart_receiver.sv
// top level: stream ports, input register, receiver core and result register
`timescale 1ns / 1ps
// an accepted item goes into the input register, then through the receiver core into the output register
// throughput: one item per cycle while not stalled, the receiver core updates once per item in a single pass
// the input register and the output register stall together only while m_tready is low
// reset (arst_n low, asynchronous): receiver disarmed, excitation off, line idle high,
// configuration back to bit_period 27, terminator 0x0A, last_index 12
module sensor_line_uart_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [0] rx_level, [7:1] zero
	input  logic [1:0]                    s_tuser,  // [1:0] op
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,  // [0] excitation, [8:1] byte_value,
	                                                // [13:9] byte_index, [14] armed, [15] zero
	output logic                          m_tuser,  // [0] byte_valid
	output logic                          m_tlast,  // line_done
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [slur_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [slur_pkg::CfgDataW-1:0] cfg_data
);
	import slur_pkg::*;

	cfg_t cfg;
	res_t core_res;
	res_t res_q;

	// input register
	logic valid_s1;
	op_t  op_s1;
	logic level_s1;

	logic out_valid_q;
	logic advance;   // the item in the input register moves into the output register

	// config writes are always taken
	assign cfg_ready = 1'b1;

	slur_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// output register free or draining this cycle
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload of the input register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= op_t'(s_tuser);
			level_s1 <= s_tdata[0];
		end
	end

	// receiver state steps exactly once per item
	slur_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.op     (op_s1),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q.armed, res_q.byte_index, res_q.byte_value, res_q.excitation};
	assign m_tuser  = res_q.byte_valid;
	assign m_tlast  = res_q.line_done;

	// end of line always comes with a byte
	a_done_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tlast || m_tuser))
		else $error("line end without a byte");

	// end of line disarms and drops excitation
	a_done_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (!m_tdata[14] && !m_tdata[0]))
		else $error("line end left receiver armed or excited");

	// input side only stalls behind a full input register
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without back-pressure");

endmodule

FILE: test/sensor_line_uart_receiver_test.sv
// self-checking testbench for the sensor line serial receiver: framed byte traffic, noise, stalls
`timescale 1ns / 1ps
module sensor_line_uart_receiver_test;
	import slur_pkg::*;

	// clock and reset
	logic clk;
	logic arst_n = 1'b0;

	// item input side
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h01;   // [0] rx_level, [7:1] zero
	logic [1:0] s_tuser  = OpTick;  // [1:0] op

	// result side
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;  // [0] excitation, [8:1] byte_value, [13:9] byte_index, [14] armed
	logic        m_tuser;  // [0] byte_valid
	logic        m_tlast;  // line_done

	// register writes
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = CfgBitPeriod;
	logic [CfgDataW-1:0] cfg_data  = '0;

	sensor_line_uart_receiver DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 2 ns period
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard limit on the run, far above the slowest legal run
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// receiver line predictor: own copy of registers and state
	// ---------------------------------------------------------------
	logic [BitPeriodW-1:0] cfg_bit_period = BitPeriodRst;
	logic [ByteW-1:0]      cfg_terminator = TerminatorRst;
	logic [PosW-1:0]       cfg_last_index = LastIndexRst;

	logic                 rx_armed   = 1'b0;
	logic                 in_frame   = 1'b0;
	logic                 prev_level = 1'b1;
	logic [TickCntW-1:0]  countdown  = '0;
	logic [ByteW-1:0]     shifter    = '0;
	logic [BitsLeftW-1:0] bits_left  = BitsPerByte;
	logic [PosW-1:0]      line_pos   = '0;
	logic                 excite     = 1'b0;

	// advance the receiver by one line tick and return what it reports
	function automatic res_t receive_tick(op_t op, logic level);
		res_t         r;
		logic [LoadW:0] first_load;
		r = '0;
		if (op == OpStart) begin
			// a new line starts cleanly, the line is not looked at on this tick
			rx_armed  = 1'b1;
			excite    = 1'b1;
			in_frame  = 1'b0;
			bits_left = BitsPerByte;
			line_pos  = '0;
		end else begin
			if (op == OpStop)
				excite = 1'b0;
			if (rx_armed) begin
				if (!in_frame) begin
					if (prev_level && !level) begin
						// falling edge: first sample one and a half bit periods out
						in_frame   = 1'b1;
						bits_left  = BitsPerByte;
						first_load = cfg_bit_period + (cfg_bit_period >> 1);
						countdown  = TickCntW'(first_load);
					end
				end else if (countdown <= 1) begin
					// a load of zero behaves as one: sample on every tick
					countdown = TickCntW'(cfg_bit_period);
					shifter   = {level, shifter[ByteW-1:1]};
					bits_left = bits_left - 1'b1;
					if (bits_left == 0) begin
						bits_left    = BitsPerByte;
						in_frame     = 1'b0;
						r.byte_valid = 1'b1;
						r.byte_value = shifter;
						r.byte_index = line_pos;
						if (shifter == cfg_terminator || line_pos == cfg_last_index) begin
							r.line_done = 1'b1;
							line_pos    = '0;
							excite      = 1'b0;
							rx_armed    = 1'b0;
						end else begin
							line_pos = line_pos + 1'b1;  // wraps past 31
						end
					end
				end else begin
					countdown = countdown - 1'b1;
				end
			end
		end
		prev_level   = level;
		r.excitation = excite;
		r.armed      = rx_armed;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// bookkeeping
	// ---------------------------------------------------------------
	res_t tick_results_due[$];
	int   ticks_sent;
	int   results_seen;
	int   mismatches;
	int   bytes_predicted;
	int   lines_ended;
	int   cfg_writes;
	int   long_hold_cycles;
	bit   tx_burst;
	bit   rx_burst;

	// ---------------------------------------------------------------
	// result receiver: random stalls, one long hold-off on request
	// ---------------------------------------------------------------
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			if (long_hold_cycles > 0) begin
				// long hold-off: block fills up and must stall its input
				m_tready <= 1'b0;
				repeat (long_hold_cycles) @(posedge clk);
				long_hold_cycles = 0;
			end
			stall = rx_burst ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (m_tvalid && m_tready) begin
			got.excitation = m_tdata[0];
			got.byte_value = m_tdata[8:1];
			got.byte_index = m_tdata[13:9];
			got.armed      = m_tdata[14];
			got.byte_valid = m_tuser;
			got.line_done  = m_tlast;
			results_seen++;
			if (tick_results_due.size() == 0) begin
				if (mismatches < 10)
					$display("result %0d arrived with nothing expected", results_seen);
				mismatches++;
			end else begin
				want = tick_results_due.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display("result %0d mismatch: expected exc=%0b valid=%0b byte=%02h",
							results_seen, want.excitation, want.byte_valid,
							want.byte_value,
							" idx=%0d done=%0b armed=%0b, got exc=%0b valid=%0b byte=%02h",
							want.byte_index, want.line_done, want.armed,
							got.excitation, got.byte_valid, got.byte_value,
							" idx=%0d done=%0b armed=%0b",
							got.byte_index, got.line_done, got.armed);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------

	// offer one tick, wait for acceptance, queue what it should report
	task automatic send_tick(op_t op, logic level, bit typed = 1'b0, res_t typed_want = '0);
		int   gap;
		res_t predicted;
		gap = tx_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'b0, level};
		do @(posedge clk); while (!s_tready);
		predicted = receive_tick(op, level);
		ticks_sent++;
		if (predicted.byte_valid)
			bytes_predicted++;
		if (predicted.line_done)
			lines_ended++;
		tick_results_due.push_back(typed ? typed_want : predicted);
	endtask

	// one register write, predictor follows at the accepting edge
	task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CfgBitPeriod:  cfg_bit_period = data;
			CfgTerminator: cfg_terminator = data[ByteW-1:0];
			CfgLastIndex:  cfg_last_index = data[PosW-1:0];
			default: ;
		endcase
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_settings(logic [15:0] period, logic [7:0] term, logic [4:0] last);
		write_register(CfgBitPeriod, period);
		write_register(CfgTerminator, {8'h00, term});
		write_register(CfgLastIndex, {11'b0, last});
	endtask

	// stop offering and wait until every result is back, then the pipeline depth
	task automatic wait_line_quiet();
		int spins;
		spins = 0;
		s_tvalid <= 1'b0;
		while (results_seen < ticks_sent && spins < 5000) begin
			@(posedge clk);
			spins++;
		end
		repeat (4) @(posedge clk);
	endtask

	// mostly plain ticks, noise_pct percent of any op (start mid-frame, stop, spare)
	function automatic op_t pick_op(int noise_pct);
		if ($urandom_range(0, 99) < noise_pct)
			return op_t'($urandom_range(0, 3));
		return OpTick;
	endfunction

	// one register setting: lines of well-formed frames with random content and some noise
	task automatic run_line_phase(logic [15:0] period, logic [7:0] term, logic [4:0] last,
			int n_bytes, int noise_pct, int term_pct);
		int         cell_ticks;
		int         line_left;
		int         k;
		logic [7:0] value;
		logic [9:0] frame;
		write_settings(period, term, last);
		cell_ticks = (period < 2) ? 1 : int'(period);
		line_left  = 0;
		repeat (n_bytes) begin
			if (line_left == 0) begin
				send_tick(OpStart, 1'b1);
				// half the lines run on until the block ends them at last_index
				line_left = $urandom_range(0, 1) ? int'(last) + 2 : $urandom_range(1, int'(last) + 1);
			end
			value = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < term_pct)
				value = term;
			// idle line between frames, occasionally glitched
			repeat ($urandom_range(0, 3))
				send_tick(pick_op(noise_pct),
					($urandom_range(0, 99) < noise_pct) ? 1'($urandom_range(0, 1)) : 1'b1);
			// start bit, eight data bits lsb first, stop bit
			frame = {1'b1, value, 1'b0};
			for (k = 0; k < 10; k++)
				repeat (cell_ticks) send_tick(pick_op(noise_pct / 4), frame[k]);
			line_left--;
		end
		wait_line_quiet();
	endtask

	// ---------------------------------------------------------------
	// directed items, run with bit_period 0 so a frame takes nine ticks
	// typed expectations where the answer is plain, predictor elsewhere
	// ---------------------------------------------------------------
	typedef struct packed {
		op_t              op;
		logic             level;
		logic             typed;
		logic             exc;
		logic             bvalid;
		logic [ByteW-1:0] value;
		logic [PosW-1:0]  index;
		logic             done;
		logic             armed;
	} step_row_t;

	step_row_t directed_rows [25] = '{
		// after reset, disarmed: edges, spare op and stop change nothing
		'{OpTick,  1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpSpare, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpStop,  1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		// start with the line low: arms and excites, no edge taken
		'{OpStart, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 5'd0, 1'b0, 1'b1},
		// stop drops excitation only
		'{OpStop,  1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b1},
		// falling edge, then all-ones byte at position 0
		'{OpTick,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b1, 1'b1, 1'b0, 1'b1, 8'hFF, 5'd0, 1'b0, 1'b1},
		// stop bit, edge, then the terminator byte 0x0a ends the line
		'{OpTick,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{OpTick,  1'b0, 1'b1, 1'b0, 1'b1, 8'h0A, 5'd1, 1'b1, 1'b0}
	};

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin : main_sequence
		res_t want;
		int   row;
		int   spins;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short bit period: a countdown load of zero samples every tick
		write_register(CfgBitPeriod, 16'd0);
		for (row = 0; row < 25; row++) begin
			want            = '0;
			want.excitation = directed_rows[row].exc;
			want.byte_valid = directed_rows[row].bvalid;
			want.byte_value = directed_rows[row].value;
			want.byte_index = directed_rows[row].index;
			want.line_done  = directed_rows[row].done;
			want.armed      = directed_rows[row].armed;
			send_tick(directed_rows[row].op, directed_rows[row].level,
				directed_rows[row].typed, want);
		end
		wait_line_quiet();

		// long lines up to position 31, no idle on either side
		tx_burst = 1'b1;
		rx_burst = 1'b1;
		run_line_phase(16'd1, 8'hFF, 5'd31, 40, 0, 0);

		// sender offers back to back while the sink holds off for a long stretch
		rx_burst = 1'b0;
		long_hold_cycles = 300;
		run_line_phase(16'd2, 8'h0A, 5'd12, 20, 5, 10);

		// random idling on both sides from here on
		tx_burst = 1'b0;
		run_line_phase(16'd3, 8'($urandom_range(0, 255)), 5'd19, 12, 10, 10);
		run_line_phase(16'd0, 8'h00, 5'd0, 15, 20, 10);

		// longest bit period: a frame starts but never reaches its first sample
		write_settings(16'hFFFF, 8'h0A, 5'd5);
		send_tick(OpStart, 1'b1);
		repeat (250) send_tick(pick_op(30), 1'($urandom_range(0, 1)));
		wait_line_quiet();

		run_line_phase(16'd2, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), 10, 10, 15);

		// drain, bounded, then allow for the pipeline depth
		spins = 0;
		while (results_seen < ticks_sent && spins < 5000) begin
			@(posedge clk);
			spins++;
		end
		repeat (8) @(posedge clk);
		if (tick_results_due.size() != 0) begin
			$display("%0d expected results never arrived", tick_results_due.size());
			mismatches++;
		end

		$display("covered %0d ticks under %0d register writes: %0d bytes, %0d line ends",
			ticks_sent, cfg_writes, bytes_predicted, lines_ended);
		$display("results checked %0d, mismatches %0d", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/slur_pkg.sv
rtl/slur_cfg_regs.sv
rtl/slur_core.sv
rtl/sensor_line_uart_receiver.sv
test/sensor_line_uart_receiver_test.sv
